### rtl/mtef_pkg.sv
// Package: widths, reset values, state and command types for the median/EMA sample filter.
package mtef_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int ALPHA_W    = 16;
  localparam int CNT_W      = 4;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = SAMPLE_W + FRAC_W;
  localparam int WINDOW_DEF = 5;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(13107);

  // register index, taken from paddr[2]
  localparam logic REG_ALPHA = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_LOAD,
    S_CMP,
    S_SEED,
    S_DIFF,
    S_MLO,
    S_MHI,
    S_SUM,
    S_UPD,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    EMA_NOP,
    EMA_SEED,
    EMA_DIFF,
    EMA_MLO,
    EMA_MHI,
    EMA_SUM,
    EMA_UPD
  } ema_op_t;

  typedef struct packed {
    ema_op_t                     op;
    logic signed [SAMPLE_W-1:0]  median;
  } ema_cmd_t;

endpackage

### rtl/mtef_in_if.sv
// Interface: sample input channel (valid/ready with sample payload).
interface mtef_in_if;
  import mtef_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       sample_ok;

  modport source (output valid, output sample, output sample_ok, input ready);
  modport sink   (input valid, input sample, input sample_ok, output ready);
endinterface

### rtl/mtef_out_if.sv
// Interface: result output channel (valid/ready with smoothed, median and fill count).
interface mtef_out_if;
  import mtef_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] smoothed;
  logic signed [SAMPLE_W-1:0] window_median;
  logic [CNT_W-1:0]           filled;

  modport source (output valid, output smoothed, output window_median, output filled,
                  input ready);
  modport sink   (input valid, input smoothed, input window_median, input filled,
                  output ready);
endinterface

### rtl/mtef_window.sv
// Sample window: register store with fill count, ring pointer and one read port.
module mtef_window #(
  parameter int WINDOW = mtef_pkg::WINDOW_DEF,
  parameter int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr,
  input  logic signed [mtef_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [IW-1:0]                       rd_addr,
  output logic signed [mtef_pkg::SAMPLE_W-1:0] rd_data,
  output logic [mtef_pkg::CNT_W-1:0]          count
);
  import mtef_pkg::*;

  logic signed [SAMPLE_W-1:0] store [WINDOW];
  logic [IW-1:0]              ring;
  logic                       full;
  logic [IW-1:0]              wr_addr;

  assign full    = (count == CNT_W'(WINDOW));
  assign wr_addr = full ? ring : count[IW-1:0];
  assign rd_data = store[rd_addr];

  always_ff @(posedge clk) begin
    if (wr) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ring  <= '0;
    end else if (wr) begin
      if (!full) begin
        count <= count + CNT_W'(1);
      end else begin
        ring <= (ring == IW'(WINDOW - 1)) ? '0 : ring + IW'(1);
      end
    end
  end

endmodule

### rtl/mtef_ema.sv
// Exponential average: accumulator with a stepped 41x8 multiply, add and shift datapath.
module mtef_ema (
  input  logic                                clk,
  input  logic                                rst,
  input  mtef_pkg::ema_cmd_t                  cmd,
  input  logic [mtef_pkg::ALPHA_W-1:0]        alpha,
  output logic                                seeded,
  output logic signed [mtef_pkg::SAMPLE_W-1:0] smoothed
);
  import mtef_pkg::*;

  localparam int DIFF_W = ACC_W + 1;
  localparam int PP_W   = DIFF_W + 9;
  localparam int PS_W   = DIFF_W + ALPHA_W;

  logic signed [ACC_W-1:0]  acc;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PP_W-1:0]   plo;
  logic signed [PP_W-1:0]   phi;
  logic signed [PS_W-1:0]   psum;
  logic signed [8:0]        alo;
  logic signed [8:0]        ahi;

  assign alo      = $signed({1'b0, alpha[7:0]});
  assign ahi      = $signed({1'b0, alpha[15:8]});
  assign smoothed = acc[ACC_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      seeded <= 1'b0;
    end else begin
      unique case (cmd.op)
        EMA_SEED: begin
          acc    <= $signed({cmd.median, FRAC_W'(0)});
          seeded <= 1'b1;
        end
        EMA_UPD: acc <= ACC_W'(DIFF_W'(acc) + DIFF_W'(psum >>> FRAC_W));
        EMA_NOP, EMA_DIFF, EMA_MLO, EMA_MHI, EMA_SUM: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      EMA_DIFF: diff <= DIFF_W'($signed({cmd.median, FRAC_W'(0)})) - DIFF_W'(acc);
      EMA_MLO:  plo  <= PP_W'(diff) * PP_W'(alo);
      EMA_MHI:  phi  <= PP_W'(diff) * PP_W'(ahi);
      EMA_SUM:  psum <= PS_W'(plo) + (PS_W'(phi) <<< 8);
      EMA_NOP, EMA_SEED, EMA_UPD: ;
      default: ;
    endcase
  end

endmodule

### rtl/median_then_ema_sample_filter_top.sv
// Top level: sliding median by rank search over a shared comparator, then exponential average.
//
//  channel   dir  handshake       payload
//  samples   in   valid/ready     sample[23:0] signed, sample_ok
//  results   out  valid/ready     smoothed[23:0], window_median[23:0], filled[3:0]
//  apb       cfg  psel/penable    ema_alpha at 0x0 (pready always high)
//
// A valid beat is written to the window; the rank search then loads each filled entry as
// candidate in turn and compares it with every entry (one compare per cycle) until one has
// rank count/2, then seeds (first median) or updates the average. An invalid beat skips both.
// samples.ready is high only while idle; a result waits in the output register
// while the next beat is accepted. Reset clears window count and average and sets
// alpha to its default.
module median_then_ema_sample_filter_top #(
  parameter int WINDOW = mtef_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  mtef_in_if.sink                       samples,
  mtef_out_if.source                    results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtef_pkg::APB_AW-1:0]   paddr,
  input  logic [mtef_pkg::APB_DW-1:0]   pwdata,
  output logic [mtef_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mtef_pkg::*;

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  state_t                     state, state_next;
  logic [ALPHA_W-1:0]         alpha;
  logic signed [SAMPLE_W-1:0] samp;
  logic                       samp_ok;
  logic                       win_wr;
  logic [IW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [CNT_W-1:0]           count;
  logic [IW-1:0]              i;
  logic [IW-1:0]              j;
  logic signed [SAMPLE_W-1:0] cand;
  logic [CNT_W-1:0]           rank;
  logic [CNT_W-1:0]           rank_new;
  logic [CNT_W-1:0]           k;
  logic                       lt;
  logic                       last_j;
  logic                       hit;
  logic signed [SAMPLE_W-1:0] last_median;
  ema_cmd_t                   ema_cmd;
  logic                       seeded;
  logic signed [SAMPLE_W-1:0] smoothed;
  logic                       out_valid;
  logic                       load_out;
  logic                       accept;
  logic                       cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ALPHA) ? APB_DW'(alpha) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RST;
    end else if (cfg_wr && paddr[2] == REG_ALPHA) begin
      alpha <= pwdata[ALPHA_W-1:0];
    end
  end

  mtef_window #(.WINDOW(WINDOW), .IW(IW)) u_window (
    .clk     (clk),
    .rst     (rst),
    .wr      (win_wr),
    .wr_data (samp),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .count   (count)
  );

  mtef_ema u_ema (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ema_cmd),
    .alpha    (alpha),
    .seeded   (seeded),
    .smoothed (smoothed)
  );

  // shared compare: strict order with index as tie break
  assign lt       = (rd_data < cand) || (rd_data == cand && j < i);
  assign rank_new = rank + CNT_W'(lt);
  assign k        = count >> 1;
  assign last_j   = (CNT_W'(j) == count - CNT_W'(1));
  assign hit      = (rank_new == k);

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    win_wr         = 1'b0;
    load_out       = 1'b0;
    rd_addr        = (state == S_CMP) ? j : i;
    ema_cmd.op     = EMA_NOP;
    ema_cmd.median = last_median;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = samples.sample_ok ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        win_wr     = samp_ok;
        state_next = S_LOAD;
      end
      S_LOAD: state_next = S_CMP;
      S_CMP: begin
        if (last_j) begin
          if (hit) begin
            state_next = seeded ? S_DIFF : S_SEED;
          end else begin
            state_next = S_LOAD;
          end
        end
      end
      S_SEED: begin
        ema_cmd.op = EMA_SEED;
        state_next = S_DONE;
      end
      S_DIFF: begin
        ema_cmd.op = EMA_DIFF;
        state_next = S_MLO;
      end
      S_MLO: begin
        ema_cmd.op = EMA_MLO;
        state_next = S_MHI;
      end
      S_MHI: begin
        ema_cmd.op = EMA_MHI;
        state_next = S_SUM;
      end
      S_SUM: begin
        ema_cmd.op = EMA_SUM;
        state_next = S_UPD;
      end
      S_UPD: begin
        ema_cmd.op = EMA_UPD;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // rank search datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      samp    <= samples.sample;
      samp_ok <= samples.sample_ok;
    end
    unique case (state)
      S_WRITE: i <= '0;
      S_LOAD: begin
        cand <= rd_data;
        j    <= '0;
        rank <= '0;
      end
      S_CMP: begin
        if (last_j) begin
          i <= i + IW'(1);
        end else begin
          j    <= j + IW'(1);
          rank <= rank_new;
        end
      end
      S_IDLE, S_SEED, S_DIFF, S_MLO, S_MHI, S_SUM, S_UPD, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_median <= '0;
    end else if (state == S_CMP && last_j && hit) begin
      last_median <= cand;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.smoothed      <= smoothed;
      results.window_median <= last_median;
      results.filled        <= count;
    end
  end

  assign results.valid = out_valid;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_fill_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && samp_ok && count < CNT_W'(WINDOW)) |=> count == $past(count) + CNT_W'(1))
    else $error("fill count did not grow on append");

  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && last_j && i == IW'(count - CNT_W'(1))) |-> hit)
    else $error("rank search ran out of candidates");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised outside done state");

endmodule

### test/tb_median_then_ema_sample_filter_top.sv
// Testbench for the median-then-EMA sample filter: directed and random samples checked against a predictor.
module tb_median_then_ema_sample_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtef_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_SETTLE = 50;
  localparam int MAX_SHOWN = 10;
  localparam logic [APB_AW-1:0] ADDR_ALPHA = {REG_ALPHA, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED = {~REG_ALPHA, 2'b00};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic signed [SAMPLE_W-1:0] median;
    logic [CNT_W-1:0]           filled;
  } filter_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  mtef_in_if  smp_if();
  mtef_out_if res_if();

  median_then_ema_sample_filter_top #(.WINDOW(WIN)) DUT (
    .clk(clk), .rst(rst),
    .samples(smp_if), .results(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // filter model state
  logic [ALPHA_W-1:0]         alpha_cfg = ALPHA_RST;
  logic signed [SAMPLE_W-1:0] win_store [WIN];
  int                         fill_cnt = 0;
  int                         ring_ptr = 0;
  longint                     avg_acc = 0;
  bit                         avg_seeded = 1'b0;
  logic signed [SAMPLE_W-1:0] last_med = '0;

  filter_result_t expected_results[$];
  int  mismatches = 0;
  int  cycle_count = 0;
  int  hold_off = 0;
  bit  no_idle = 1'b0;
  int  load_base = 0;

  function automatic filter_result_t filter_step(logic signed [SAMPLE_W-1:0] s, logic ok);
    filter_result_t r;
    logic signed [SAMPLE_W-1:0] srt [WIN];
    logic signed [SAMPLE_W-1:0] key;
    int j;
    longint diff;
    if (ok) begin
      if (fill_cnt < WIN) begin
        win_store[fill_cnt] = s;
        fill_cnt++;
      end else begin
        win_store[ring_ptr] = s;
        ring_ptr = (ring_ptr + 1) % WIN;
      end
      for (int i = 0; i < fill_cnt; i++) srt[i] = win_store[i];
      for (int i = 1; i < fill_cnt; i++) begin
        key = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > key) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = key;
      end
      last_med = srt[fill_cnt / 2];
      if (!avg_seeded) begin
        avg_acc = longint'(last_med) <<< FRAC_W;
        avg_seeded = 1'b1;
      end else begin
        diff = (longint'(last_med) <<< FRAC_W) - avg_acc;
        avg_acc += (diff * longint'(alpha_cfg)) >>> FRAC_W;
      end
    end
    r.smoothed = SAMPLE_W'(avg_acc >>> FRAC_W);
    r.median   = last_med;
    r.filled   = CNT_W'(fill_cnt);
    return r;
  endfunction

  // slowly drifting load with noise, plus occasional full-range and extreme readings
  function automatic logic signed [SAMPLE_W-1:0] next_reading();
    case ($urandom_range(0, 9))
      0, 1: return SAMPLE_W'($urandom);
      2:    return $urandom_range(0, 1) ? S_MAX : S_MIN;
      default: begin
        load_base += int'($urandom_range(0, 2000)) - 1000;
        return SAMPLE_W'(load_base + int'($urandom_range(0, 64)) - 32);
      end
    endcase
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t %s: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ALPHA) alpha_cfg = data[ALPHA_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_check_alpha();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_ALPHA;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("ema_alpha readback", longint'(alpha_cfg), longint'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // called at a falling edge; leaves valid high so back-to-back beats need no toggle
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic ok);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    smp_if.valid <= 1'b1;
    smp_if.sample <= s;
    smp_if.sample_ok <= ok;
    do @(posedge clk); while (!smp_if.ready);
    expected_results.push_back(filter_step(s, ok));
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(next_reading(), $urandom_range(0, 7) != 0);
  endtask

  task automatic wait_results_drained();
    smp_if.valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_reset_state();
    apb_check_alpha();
    send_sample(SAMPLE_W'($urandom), 1'b0);
    send_sample(S_MIN, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_window_fill();
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b1);
    send_sample('0, 1'b1);
    send_sample(-1, 1'b1);
    send_sample(S_MAX, 1'b0);
    send_sample(1, 1'b1);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MAX, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_alpha_settings();
    logic [ALPHA_W-1:0] vals [5];
    vals = '{'0, '1, ALPHA_W'(1), ALPHA_W'(32768), ALPHA_W'($urandom)};
    foreach (vals[k]) begin
      apb_write(ADDR_ALPHA, {16'($urandom), vals[k]});
      apb_check_alpha();
      apb_write(ADDR_UNMAPPED, $urandom);
      apb_check_alpha();
      send_sample(S_MIN, 1'b1);
      send_sample(S_MAX, 1'b1);
      send_random(70);
      wait_results_drained();
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    send_random(12);
    wait_results_drained();
  endtask

  task automatic test_random_stream();
    apb_write(ADDR_ALPHA, $urandom);
    send_random(450);
    wait_results_drained();
    apb_write(ADDR_ALPHA, $urandom);
    no_idle = 1'b1;
    send_random(100);
    wait_results_drained();
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    filter_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t unexpected beat: expected none, got median %0d", $realtime,
                   $signed(res_if.window_median));
      end else begin
        want = expected_results.pop_front();
        check_field("smoothed", longint'($signed(want.smoothed)),
                    longint'($signed(res_if.smoothed)));
        check_field("window_median", longint'($signed(want.median)),
                    longint'($signed(res_if.window_median)));
        check_field("filled", longint'(want.filled), longint'(res_if.filled));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    smp_if.sample_ok = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_window_fill();
    test_alpha_settings();
    test_backpressure();
    test_random_stream();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
rtl/mtef_pkg.sv
rtl/mtef_in_if.sv
rtl/mtef_out_if.sv
rtl/mtef_window.sv
rtl/mtef_ema.sv
rtl/median_then_ema_sample_filter_top.sv
test/tb_median_then_ema_sample_filter_top.sv
